// ===== rtl/mavtc_pkg.sv =====
// Shared constants, register codes and state types for the tilt compensator.
package mavtc_pkg;

   localparam int MAX_WINDOW_DEFAULT = 16;
   localparam int ANGLE_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH        = 2;

   localparam int WINDOW_W   = 5;
   localparam int CSR_ADDR_W = 3;

   // Register reset values (angles in Q3.12 radians)
   localparam int WINDOW_RESET      = 5;
   localparam int ROLL_LOWER_RESET  = -6431;
   localparam int ROLL_UPPER_RESET  = 6431;
   localparam int PITCH_LOWER_RESET = -6431;
   localparam int PITCH_UPPER_RESET = 3215;
   localparam int ROLL_BIAS_RESET   = -6431;
   localparam int PITCH_BIAS_RESET  = 0;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_WINDOW_LENGTH     = 3'd0,
      CSR_ROLL_LOWER_LIMIT  = 3'd1,
      CSR_ROLL_UPPER_LIMIT  = 3'd2,
      CSR_PITCH_LOWER_LIMIT = 3'd3,
      CSR_PITCH_UPPER_LIMIT = 3'd4,
      CSR_ROLL_BIAS         = 3'd5,
      CSR_PITCH_BIAS        = 3'd6
   } csr_index_type;

   typedef enum logic {
      FRONT_IDLE,
      FRONT_UPDATE
   } front_state_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIVIDE,
      BACK_POST
   } back_state_type;

endpackage

// ===== rtl/mavtc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mavtc_ram #(
   parameter int WIDTH = mavtc_pkg::ANGLE_BITS_DEFAULT,
   parameter int DEPTH = mavtc_pkg::MAX_WINDOW_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mavtc_front.sv =====
// Front end: takes samples, updates history stores and running sums, queues jobs.
module mavtc_front #(
   parameter int MAX_WINDOW = mavtc_pkg::MAX_WINDOW_DEFAULT,
   parameter int ANGLE_BITS = mavtc_pkg::ANGLE_BITS_DEFAULT,
   localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
   localparam int LEN_W  = $clog2(MAX_WINDOW + 1),
   localparam int TOT_W  = ANGLE_BITS + $clog2(MAX_WINDOW),
   localparam int JOB_W  = 2 * TOT_W + LEN_W
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  clear,
   input  logic [mavtc_pkg::WINDOW_W-1:0]        window_length,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic signed [ANGLE_BITS-1:0]          roll_angle,
   input  logic signed [ANGLE_BITS-1:0]          pitch_angle,
   output logic                                  job_valid,
   input  logic                                  job_ready,
   output logic [JOB_W-1:0]                      job_data
);

   localparam int CMP_W = (LEN_W > mavtc_pkg::WINDOW_W) ? LEN_W : mavtc_pkg::WINDOW_W;

   mavtc_pkg::front_state_type state_ff, state_in;

   logic [SLOT_W-1:0]           slot_ff, slot_in;
   logic [MAX_WINDOW-1:0]       valid_ff, valid_in;
   logic signed [TOT_W-1:0]     roll_total_ff, roll_total_in;
   logic signed [TOT_W-1:0]     pitch_total_ff, pitch_total_in;
   logic signed [ANGLE_BITS-1:0] roll_ff, roll_in;
   logic signed [ANGLE_BITS-1:0] pitch_ff, pitch_in;

   logic                        ram_re;
   logic                        ram_we;
   logic [ANGLE_BITS-1:0]       roll_q;
   logic [ANGLE_BITS-1:0]       pitch_q;
   logic signed [ANGLE_BITS-1:0] roll_old;
   logic signed [ANGLE_BITS-1:0] pitch_old;
   logic [CMP_W-1:0]            win_ext;
   logic [LEN_W-1:0]            len;
   logic [LEN_W:0]              slot_next;
   logic                        commit;

   // Effective window: zero acts as one, long windows cap at the store depth
   always_comb begin
      win_ext = CMP_W'(window_length);
      if (window_length == '0) begin
         len = LEN_W'(1);
      end else if (win_ext > CMP_W'(MAX_WINDOW)) begin
         len = LEN_W'(MAX_WINDOW);
      end else begin
         len = LEN_W'(win_ext);
      end
   end

   mavtc_ram #(.WIDTH(ANGLE_BITS), .DEPTH(MAX_WINDOW)) u_roll_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (slot_ff),
      .wr_data (roll_ff),
      .rd_en   (ram_re),
      .rd_addr (slot_ff),
      .rd_data (roll_q)
   );

   mavtc_ram #(.WIDTH(ANGLE_BITS), .DEPTH(MAX_WINDOW)) u_pitch_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (slot_ff),
      .wr_data (pitch_ff),
      .rd_en   (ram_re),
      .rd_addr (slot_ff),
      .rd_data (pitch_q)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mavtc_pkg::FRONT_IDLE: begin
            if (req_tvalid) begin
               state_in = mavtc_pkg::FRONT_UPDATE;
            end
         end
         mavtc_pkg::FRONT_UPDATE: begin
            if (job_ready) begin
               state_in = mavtc_pkg::FRONT_IDLE;
            end
         end
         default: state_in = mavtc_pkg::FRONT_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      ram_re     = 1'b0;
      job_valid  = 1'b0;
      ram_we     = 1'b0;
      unique case (state_ff)
         mavtc_pkg::FRONT_IDLE: begin
            req_tready = 1'b1;
            ram_re     = req_tvalid;
         end
         mavtc_pkg::FRONT_UPDATE: begin
            job_valid = 1'b1;
            ram_we    = job_ready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   assign commit = job_valid && job_ready;

   always_comb begin
      // An entry not written since the last clear reads as zero
      roll_old  = valid_ff[slot_ff] ? $signed(roll_q) : '0;
      pitch_old = valid_ff[slot_ff] ? $signed(pitch_q) : '0;

      roll_total_in  = roll_total_ff + TOT_W'(roll_ff) - TOT_W'(roll_old);
      pitch_total_in = pitch_total_ff + TOT_W'(pitch_ff) - TOT_W'(pitch_old);

      slot_next = (LEN_W + 1)'(slot_ff) + (LEN_W + 1)'(1);
      slot_in   = (slot_next >= (LEN_W + 1)'(len)) ? '0 : SLOT_W'(slot_next);

      valid_in          = valid_ff;
      valid_in[slot_ff] = 1'b1;

      roll_in  = (req_tvalid && req_tready) ? roll_angle : roll_ff;
      pitch_in = (req_tvalid && req_tready) ? pitch_angle : pitch_ff;
   end

   assign job_data = {len, pitch_total_in, roll_total_in};

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         slot_ff        <= '0;
         valid_ff       <= '0;
         roll_total_ff  <= '0;
         pitch_total_ff <= '0;
      end else if (commit) begin
         slot_ff        <= slot_in;
         valid_ff       <= valid_in;
         roll_total_ff  <= roll_total_in;
         pitch_total_ff <= pitch_total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mavtc_pkg::FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      roll_ff  <= roll_in;
      pitch_ff <= pitch_in;
   end

endmodule

// ===== rtl/mavtc_queue.sv =====
// Short FIFO of sum jobs between the front end and the divider back end.
module mavtc_queue #(
   parameter int WIDTH = 2 * mavtc_pkg::ANGLE_BITS_DEFAULT,
   parameter int DEPTH = mavtc_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/mavtc_back.sv =====
// Back end: serial division of both sums, clamp, bias, saturate, result register.
module mavtc_back #(
   parameter int MAX_WINDOW = mavtc_pkg::MAX_WINDOW_DEFAULT,
   parameter int ANGLE_BITS = mavtc_pkg::ANGLE_BITS_DEFAULT,
   localparam int LEN_W   = $clog2(MAX_WINDOW + 1),
   localparam int TOT_W   = ANGLE_BITS + $clog2(MAX_WINDOW),
   localparam int JOB_W   = 2 * TOT_W + LEN_W,
   localparam int TDATA_W = ((2 * ANGLE_BITS + 7) / 8) * 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         job_valid,
   output logic                         job_ready,
   input  logic [JOB_W-1:0]             job_data,
   input  logic signed [ANGLE_BITS-1:0] roll_lower_limit,
   input  logic signed [ANGLE_BITS-1:0] roll_upper_limit,
   input  logic signed [ANGLE_BITS-1:0] pitch_lower_limit,
   input  logic signed [ANGLE_BITS-1:0] pitch_upper_limit,
   input  logic signed [ANGLE_BITS-1:0] roll_bias,
   input  logic signed [ANGLE_BITS-1:0] pitch_bias,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [TDATA_W-1:0]           rsp_tdata
);

   localparam int CNT_W = $clog2(TOT_W);
   localparam int TW1   = TOT_W + 1;
   localparam int AB1   = ANGLE_BITS + 1;

   function automatic logic [TOT_W-1:0] magnitude(input logic [TOT_W-1:0] v);
      return v[TOT_W-1] ? (~v + TOT_W'(1)) : v;
   endfunction

   // Negate the quotient, clamp (lower limit tested first), add bias, saturate
   function automatic logic signed [ANGLE_BITS-1:0] axis_command(
      input logic [TOT_W-1:0]             quo,
      input logic                         neg,
      input logic signed [ANGLE_BITS-1:0] lo,
      input logic signed [ANGLE_BITS-1:0] hi,
      input logic signed [ANGLE_BITS-1:0] bias
   );
      logic signed [TOT_W:0]        c;
      logic signed [TOT_W:0]        lo_e;
      logic signed [TOT_W:0]        hi_e;
      logic signed [ANGLE_BITS-1:0] cl;
      logic signed [ANGLE_BITS:0]   sum;
      logic signed [ANGLE_BITS-1:0] res;
      c    = neg ? $signed({1'b0, quo}) : -$signed({1'b0, quo});
      lo_e = TW1'(lo);
      hi_e = TW1'(hi);
      if (c < lo_e) begin
         cl = lo;
      end else if (c > hi_e) begin
         cl = hi;
      end else begin
         cl = $signed(c[ANGLE_BITS-1:0]);
      end
      sum = AB1'(cl) + AB1'(bias);
      if (sum[ANGLE_BITS] != sum[ANGLE_BITS-1]) begin
         res = sum[ANGLE_BITS] ? $signed({1'b1, {(ANGLE_BITS - 1){1'b0}}})
                               : $signed({1'b0, {(ANGLE_BITS - 1){1'b1}}});
      end else begin
         res = $signed(sum[ANGLE_BITS-1:0]);
      end
      return res;
   endfunction

   mavtc_pkg::back_state_type state_ff, state_in;

   logic                         axis_ff, axis_in;
   logic                         neg_ff, neg_in;
   logic [TOT_W-1:0]             dq_ff, dq_in;
   logic [LEN_W-1:0]             rem_ff, rem_in;
   logic [LEN_W-1:0]             len_ff, len_in;
   logic [TOT_W-1:0]             pitch_total_ff, pitch_total_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic signed [ANGLE_BITS-1:0] roll_cmd_ff, roll_cmd_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [ANGLE_BITS-1:0] rsp_roll_ff, rsp_roll_in;
   logic signed [ANGLE_BITS-1:0] rsp_pitch_ff, rsp_pitch_in;

   logic [TOT_W-1:0]             job_roll;
   logic [TOT_W-1:0]             job_pitch;
   logic [LEN_W-1:0]             job_len;
   logic [LEN_W:0]               trial;
   logic                         fits;
   logic signed [ANGLE_BITS-1:0] cmd;
   logic                         out_free;
   logic                         last_step;

   assign job_roll  = job_data[TOT_W-1:0];
   assign job_pitch = job_data[2*TOT_W-1:TOT_W];
   assign job_len   = job_data[JOB_W-1:2*TOT_W];

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign last_step = (cnt_ff == CNT_W'(TOT_W - 1));

   // Restoring division step: one quotient bit per cycle
   assign trial = {rem_ff, dq_ff[TOT_W-1]};
   assign fits  = (trial >= {1'b0, len_ff});

   assign cmd = axis_ff ? axis_command(dq_ff, neg_ff, pitch_lower_limit,
                                       pitch_upper_limit, pitch_bias)
                        : axis_command(dq_ff, neg_ff, roll_lower_limit,
                                       roll_upper_limit, roll_bias);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mavtc_pkg::BACK_IDLE: begin
            if (job_valid) begin
               state_in = mavtc_pkg::BACK_DIVIDE;
            end
         end
         mavtc_pkg::BACK_DIVIDE: begin
            if (last_step) begin
               state_in = mavtc_pkg::BACK_POST;
            end
         end
         mavtc_pkg::BACK_POST: begin
            if (!axis_ff) begin
               state_in = mavtc_pkg::BACK_DIVIDE;
            end else if (out_free) begin
               state_in = mavtc_pkg::BACK_IDLE;
            end
         end
         default: state_in = mavtc_pkg::BACK_IDLE;
      endcase
   end

   always_comb begin
      job_ready = 1'b0;
      unique case (state_ff)
         mavtc_pkg::BACK_IDLE:   job_ready = 1'b1;
         mavtc_pkg::BACK_DIVIDE: job_ready = 1'b0;
         mavtc_pkg::BACK_POST:   job_ready = 1'b0;
         default:                job_ready = 1'b0;
      endcase
   end

   always_comb begin
      axis_in        = axis_ff;
      neg_in         = neg_ff;
      dq_in          = dq_ff;
      rem_in         = rem_ff;
      len_in         = len_ff;
      pitch_total_in = pitch_total_ff;
      cnt_in         = cnt_ff;
      roll_cmd_in    = roll_cmd_ff;
      rsp_roll_in    = rsp_roll_ff;
      rsp_pitch_in   = rsp_pitch_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         mavtc_pkg::BACK_IDLE: begin
            if (job_valid) begin
               len_in         = job_len;
               pitch_total_in = job_pitch;
               dq_in          = magnitude(job_roll);
               neg_in         = job_roll[TOT_W-1];
               rem_in         = '0;
               cnt_in         = '0;
               axis_in        = 1'b0;
            end
         end
         mavtc_pkg::BACK_DIVIDE: begin
            dq_in  = {dq_ff[TOT_W-2:0], fits};
            rem_in = fits ? LEN_W'(trial - {1'b0, len_ff}) : LEN_W'(trial);
            cnt_in = cnt_ff + CNT_W'(1);
         end
         mavtc_pkg::BACK_POST: begin
            if (!axis_ff) begin
               roll_cmd_in = cmd;
               dq_in       = magnitude(pitch_total_ff);
               neg_in      = pitch_total_ff[TOT_W-1];
               rem_in      = '0;
               cnt_in      = '0;
               axis_in     = 1'b1;
            end else if (out_free) begin
               rsp_roll_in  = roll_cmd_ff;
               rsp_pitch_in = cmd;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mavtc_pkg::BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      axis_ff        <= axis_in;
      neg_ff         <= neg_in;
      dq_ff          <= dq_in;
      rem_ff         <= rem_in;
      len_ff         <= len_in;
      pitch_total_ff <= pitch_total_in;
      cnt_ff         <= cnt_in;
      roll_cmd_ff    <= roll_cmd_in;
      rsp_roll_ff    <= rsp_roll_in;
      rsp_pitch_ff   <= rsp_pitch_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_W'({rsp_pitch_ff, rsp_roll_ff});

endmodule

// ===== rtl/moving_average_tilt_compensator.sv =====
// Top level: register file and the front end, job queue and divider back end.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  roll_angle, pitch_angle
//   rsp      out        rsp_tvalid/rsp_tready  roll_command, pitch_command
//   csr      in         csr_we                 csr_addr selects, csr_wdata
//
// In the back end the shared one-bit-per-cycle divider runs twice per item and
// sets the rate. For each item the front end reads the history, then updates
// it once the queue takes the job, and it runs ahead by up to two queued jobs.
// Reset and a window_length write clear the stores, sums and write slot at
// once. A stalled rsp side holds one result and lets the queue fill.
module moving_average_tilt_compensator #(
   parameter int MAX_WINDOW = mavtc_pkg::MAX_WINDOW_DEFAULT,
   parameter int ANGLE_BITS = mavtc_pkg::ANGLE_BITS_DEFAULT,
   localparam int TDATA_W = ((2 * ANGLE_BITS + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [TDATA_W-1:0]                req_tdata,  // roll_angle, pitch_angle, zero pad
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [TDATA_W-1:0]                rsp_tdata,  // roll_command, pitch_command, zero pad
   input  logic                              csr_we,
   input  logic [mavtc_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [ANGLE_BITS-1:0]             csr_wdata
);

   localparam int LEN_W = $clog2(MAX_WINDOW + 1);
   localparam int TOT_W = ANGLE_BITS + $clog2(MAX_WINDOW);
   localparam int JOB_W = 2 * TOT_W + LEN_W;

   logic [mavtc_pkg::WINDOW_W-1:0] window_ff, window_in;
   logic signed [ANGLE_BITS-1:0]   roll_lo_ff, roll_lo_in;
   logic signed [ANGLE_BITS-1:0]   roll_hi_ff, roll_hi_in;
   logic signed [ANGLE_BITS-1:0]   pitch_lo_ff, pitch_lo_in;
   logic signed [ANGLE_BITS-1:0]   pitch_hi_ff, pitch_hi_in;
   logic signed [ANGLE_BITS-1:0]   roll_bias_ff, roll_bias_in;
   logic signed [ANGLE_BITS-1:0]   pitch_bias_ff, pitch_bias_in;
   logic                           window_clear;

   logic                           push_valid;
   logic                           push_ready;
   logic [JOB_W-1:0]               push_data;
   logic                           pop_valid;
   logic                           pop_ready;
   logic [JOB_W-1:0]               pop_data;

   always_comb begin
      window_in     = window_ff;
      roll_lo_in    = roll_lo_ff;
      roll_hi_in    = roll_hi_ff;
      pitch_lo_in   = pitch_lo_ff;
      pitch_hi_in   = pitch_hi_ff;
      roll_bias_in  = roll_bias_ff;
      pitch_bias_in = pitch_bias_ff;
      window_clear  = 1'b0;
      if (csr_we) begin
         unique case (mavtc_pkg::csr_index_type'(csr_addr))
            mavtc_pkg::CSR_WINDOW_LENGTH: begin
               window_in    = csr_wdata[mavtc_pkg::WINDOW_W-1:0];
               window_clear = 1'b1;
            end
            mavtc_pkg::CSR_ROLL_LOWER_LIMIT:  roll_lo_in    = $signed(csr_wdata);
            mavtc_pkg::CSR_ROLL_UPPER_LIMIT:  roll_hi_in    = $signed(csr_wdata);
            mavtc_pkg::CSR_PITCH_LOWER_LIMIT: pitch_lo_in   = $signed(csr_wdata);
            mavtc_pkg::CSR_PITCH_UPPER_LIMIT: pitch_hi_in   = $signed(csr_wdata);
            mavtc_pkg::CSR_ROLL_BIAS:         roll_bias_in  = $signed(csr_wdata);
            mavtc_pkg::CSR_PITCH_BIAS:        pitch_bias_in = $signed(csr_wdata);
            default: window_clear = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff     <= mavtc_pkg::WINDOW_W'(mavtc_pkg::WINDOW_RESET);
         roll_lo_ff    <= ANGLE_BITS'(mavtc_pkg::ROLL_LOWER_RESET);
         roll_hi_ff    <= ANGLE_BITS'(mavtc_pkg::ROLL_UPPER_RESET);
         pitch_lo_ff   <= ANGLE_BITS'(mavtc_pkg::PITCH_LOWER_RESET);
         pitch_hi_ff   <= ANGLE_BITS'(mavtc_pkg::PITCH_UPPER_RESET);
         roll_bias_ff  <= ANGLE_BITS'(mavtc_pkg::ROLL_BIAS_RESET);
         pitch_bias_ff <= ANGLE_BITS'(mavtc_pkg::PITCH_BIAS_RESET);
      end else begin
         window_ff     <= window_in;
         roll_lo_ff    <= roll_lo_in;
         roll_hi_ff    <= roll_hi_in;
         pitch_lo_ff   <= pitch_lo_in;
         pitch_hi_ff   <= pitch_hi_in;
         roll_bias_ff  <= roll_bias_in;
         pitch_bias_ff <= pitch_bias_in;
      end
   end

   mavtc_front #(.MAX_WINDOW(MAX_WINDOW), .ANGLE_BITS(ANGLE_BITS)) u_front (
      .clock         (clock),
      .reset         (reset),
      .clear         (window_clear),
      .window_length (window_ff),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .roll_angle    ($signed(req_tdata[ANGLE_BITS-1:0])),
      .pitch_angle   ($signed(req_tdata[2*ANGLE_BITS-1:ANGLE_BITS])),
      .job_valid     (push_valid),
      .job_ready     (push_ready),
      .job_data      (push_data)
   );

   mavtc_queue #(.WIDTH(JOB_W), .DEPTH(mavtc_pkg::QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   mavtc_back #(.MAX_WINDOW(MAX_WINDOW), .ANGLE_BITS(ANGLE_BITS)) u_back (
      .clock             (clock),
      .reset             (reset),
      .job_valid         (pop_valid),
      .job_ready         (pop_ready),
      .job_data          (pop_data),
      .roll_lower_limit  (roll_lo_ff),
      .roll_upper_limit  (roll_hi_ff),
      .pitch_lower_limit (pitch_lo_ff),
      .pitch_upper_limit (pitch_hi_ff),
      .roll_bias         (roll_bias_ff),
      .pitch_bias        (pitch_bias_ff),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata)
   );

endmodule
